/* hdl/htd_pkg.sv */
// Shared types and constants of the Huffman tree decoder.
// Node entry layout, request and status codes and sequencer states.
// No dependencies.
`default_nettype none

package htd_pkg;

  localparam int NODES        = 511;
  localparam int MAX_CODE_LEN = 32;
  localparam int SYM_W        = 8;
  localparam int CODE_W       = 32;
  localparam int CIDX_W       = $clog2(CODE_W);
  localparam int LEN_W        = 6;
  localparam int BYTE_W       = 8;
  localparam int VB_W         = 4;
  localparam int NODE_W       = $clog2(NODES);
  localparam int CNT_W        = $clog2(NODES + 1);
  localparam int REM_W        = $clog2(MAX_CODE_LEN + 1);
  localparam int SUM_W        = CNT_W + REM_W;
  localparam int BITS_W       = $clog2(BYTE_W + 1);
  localparam int IN_DATA_W    = 64;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_DECODE = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STAT_SYMBOL   = 2'd0,
    STAT_LOAD_OK  = 2'd1,
    STAT_BAD_CODE = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_WALK,
    S_LD_BUILD,
    S_LD_FINAL,
    S_DEC,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic [SYM_W-1:0]  sym;
  } node_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    node_t             data;
  } mem_wr_t;

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] sym;
    status_t          status;
    logic             last;
  } result_t;

endpackage

`default_nettype wire

/* hdl/htd_node_mem.sv */
// Node table memory: one write port, one read port with registered data.
// Uses htd_pkg for the node entry type and depth.
`default_nettype none

module htd_node_mem (
  input  wire                     clk,
  input  htd_pkg::mem_wr_t        wr,
  input  wire [htd_pkg::NODE_W-1:0] rd_addr,
  output htd_pkg::node_t          rd_data
);

  htd_pkg::node_t mem [htd_pkg::NODES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hdl/htd_step.sv */
// Shared tree step unit: picks the child link for one bit and flags a node
// that has no children. Uses htd_pkg for the node entry type.
`default_nettype none

module htd_step (
  input  htd_pkg::node_t            entry,
  input  wire                       bit_in,
  output logic [htd_pkg::NODE_W-1:0] child,
  output logic                      no_child,
  output logic                      leaf
);

  always_comb begin
    child    = bit_in ? entry.right : entry.left;
    no_child = (child == '0);
    leaf     = (entry.left == '0) && (entry.right == '0);
  end

endmodule

`default_nettype wire

/* hdl/htd_ctrl.sv */
// Sequencer of the tree decoder: load walk and node build, decode walk,
// clear, and the pending result that learns its last flag late.
// Uses htd_pkg, htd_step and htd_node_mem.
`default_nettype none

module htd_ctrl (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          req_valid,
  output logic                         req_ready,
  input  htd_pkg::func_t               func,
  input  wire [htd_pkg::SYM_W-1:0]     symbol_in,
  input  wire [htd_pkg::CODE_W-1:0]    code_bits,
  input  wire [htd_pkg::LEN_W-1:0]     code_length,
  input  wire [htd_pkg::BYTE_W-1:0]    data_byte,
  input  wire [htd_pkg::VB_W-1:0]      valid_bits,
  input  wire                          out_room,
  output htd_pkg::result_t             push
);

  htd_pkg::state_t              state, state_next;
  logic [htd_pkg::NODE_W-1:0]   walk_pos, walk_pos_next;
  logic [htd_pkg::NODE_W-1:0]   cur, cur_next;
  logic [htd_pkg::CNT_W-1:0]    node_count, node_count_next;
  logic [htd_pkg::NODE_W-1:0]   root_left, root_left_next;
  logic [htd_pkg::NODE_W-1:0]   root_right, root_right_next;
  htd_pkg::node_t               work, work_next;
  logic                         pend_valid, pend_valid_next;
  logic [htd_pkg::SYM_W-1:0]    pend_sym, pend_sym_next;
  htd_pkg::status_t             pend_status, pend_status_next;
  logic [htd_pkg::SYM_W-1:0]    item_sym, item_sym_next;
  logic [htd_pkg::CODE_W-1:0]   item_code, item_code_next;
  logic [htd_pkg::REM_W-1:0]    rem, rem_next;
  logic [htd_pkg::BYTE_W-1:0]   byte_sh, byte_sh_next;
  logic [htd_pkg::BITS_W-1:0]   bits_left, bits_left_next;

  htd_pkg::node_t               root_entry, rd_data, step_entry, upd;
  htd_pkg::mem_wr_t             wr;
  logic [htd_pkg::NODE_W-1:0]   rd_addr, child;
  logic                         step_bit, no_child, leaf, code_bit, can_emit;
  logic [htd_pkg::REM_W-1:0]    rem_m1, len_sat;
  logic [htd_pkg::SUM_W-1:0]    need;

  htd_node_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  htd_step u_step (
    .entry    (step_entry),
    .bit_in   (step_bit),
    .child    (child),
    .no_child (no_child),
    .leaf     (leaf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= htd_pkg::S_IDLE;
      walk_pos   <= '0;
      node_count <= htd_pkg::CNT_W'(1);
      root_left  <= '0;
      root_right <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      walk_pos   <= walk_pos_next;
      node_count <= node_count_next;
      root_left  <= root_left_next;
      root_right <= root_right_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur         <= cur_next;
    work        <= work_next;
    pend_sym    <= pend_sym_next;
    pend_status <= pend_status_next;
    item_sym    <= item_sym_next;
    item_code   <= item_code_next;
    rem         <= rem_next;
    byte_sh     <= byte_sh_next;
    bits_left   <= bits_left_next;
  end

  always_comb begin
    root_entry = '{left: root_left, right: root_right, sym: '0};
    rem_m1     = rem - 1'b1;
    code_bit   = (int'(rem_m1) < htd_pkg::CODE_W) ?
                 item_code[rem_m1[htd_pkg::CIDX_W-1:0]] : 1'b0;
    if (int'(code_length) > htd_pkg::MAX_CODE_LEN) begin
      len_sat = htd_pkg::REM_W'(htd_pkg::MAX_CODE_LEN);
    end else begin
      len_sat = htd_pkg::REM_W'(code_length);
    end
    need     = htd_pkg::SUM_W'(node_count) + htd_pkg::SUM_W'(rem);
    can_emit = !pend_valid || out_room;

    // feed the shared step unit from the load walk or the decode walk
    if (state == htd_pkg::S_DEC) begin
      step_entry = (walk_pos == '0) ? root_entry : rd_data;
      step_bit   = byte_sh[htd_pkg::BYTE_W-1];
    end else begin
      step_entry = (cur == '0) ? root_entry : rd_data;
      step_bit   = code_bit;
    end

    upd = work;
    if (code_bit) begin
      upd.right = htd_pkg::NODE_W'(node_count);
    end else begin
      upd.left = htd_pkg::NODE_W'(node_count);
    end
  end

  always_comb begin
    state_next       = state;
    walk_pos_next    = walk_pos;
    cur_next         = cur;
    node_count_next  = node_count;
    root_left_next   = root_left;
    root_right_next  = root_right;
    work_next        = work;
    pend_valid_next  = pend_valid;
    pend_sym_next    = pend_sym;
    pend_status_next = pend_status;
    item_sym_next    = item_sym;
    item_code_next   = item_code;
    rem_next         = rem;
    byte_sh_next     = byte_sh;
    bits_left_next   = bits_left;
    req_ready        = 1'b0;
    push             = '0;
    wr               = '0;

    unique case (state)
      htd_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          unique case (func)
            htd_pkg::FUNC_LOAD: begin
              item_sym_next  = symbol_in;
              item_code_next = code_bits;
              rem_next       = len_sat;
              cur_next       = '0;
              if (len_sat == '0) begin
                pend_valid_next  = 1'b1;
                pend_sym_next    = '0;
                pend_status_next = htd_pkg::STAT_LOAD_OK;
                state_next       = htd_pkg::S_FLUSH;
              end else begin
                state_next = htd_pkg::S_LD_WALK;
              end
            end
            htd_pkg::FUNC_DECODE: begin
              byte_sh_next = data_byte;
              if (int'(valid_bits) > htd_pkg::BYTE_W) begin
                bits_left_next = htd_pkg::BITS_W'(htd_pkg::BYTE_W);
              end else begin
                bits_left_next = htd_pkg::BITS_W'(valid_bits);
              end
              state_next = htd_pkg::S_DEC;
            end
            htd_pkg::FUNC_CLEAR: begin
              root_left_next  = '0;
              root_right_next = '0;
              node_count_next = htd_pkg::CNT_W'(1);
              walk_pos_next   = '0;
              state_next      = htd_pkg::S_FLUSH;
            end
            default: begin
              state_next = htd_pkg::S_FLUSH;
            end
          endcase
        end
      end

      htd_pkg::S_LD_WALK: begin
        if (rem == '0) begin
          // whole path exists: overwrite the symbol of its last node
          work_next  = step_entry;
          state_next = htd_pkg::S_LD_FINAL;
        end else if (!no_child) begin
          cur_next = child;
          rem_next = rem - 1'b1;
        end else if (need > htd_pkg::SUM_W'(htd_pkg::NODES)) begin
          pend_valid_next  = 1'b1;
          pend_sym_next    = '0;
          pend_status_next = htd_pkg::STAT_FULL;
          state_next       = htd_pkg::S_FLUSH;
        end else begin
          work_next  = step_entry;
          state_next = htd_pkg::S_LD_BUILD;
        end
      end

      htd_pkg::S_LD_BUILD: begin
        // link a fresh node under cur; its own entry is written in the step after
        if (cur == '0) begin
          root_left_next  = upd.left;
          root_right_next = upd.right;
        end else begin
          wr = '{en: 1'b1, addr: cur, data: upd};
        end
        work_next       = '0;
        cur_next        = htd_pkg::NODE_W'(node_count);
        node_count_next = node_count + 1'b1;
        rem_next        = rem - 1'b1;
        if (rem == htd_pkg::REM_W'(1)) begin
          state_next = htd_pkg::S_LD_FINAL;
        end
      end

      htd_pkg::S_LD_FINAL: begin
        wr = '{en: 1'b1, addr: cur,
               data: '{left: work.left, right: work.right, sym: item_sym}};
        pend_valid_next  = 1'b1;
        pend_sym_next    = '0;
        pend_status_next = htd_pkg::STAT_LOAD_OK;
        state_next       = htd_pkg::S_FLUSH;
      end

      htd_pkg::S_DEC: begin
        if (walk_pos != '0 && leaf) begin
          if (can_emit) begin
            if (pend_valid) begin
              push = '{valid: 1'b1, sym: pend_sym, status: pend_status, last: 1'b0};
            end
            pend_valid_next  = 1'b1;
            pend_sym_next    = step_entry.sym;
            pend_status_next = htd_pkg::STAT_SYMBOL;
            walk_pos_next    = '0;
          end
        end else if (bits_left != '0) begin
          if (no_child) begin
            if (can_emit) begin
              if (pend_valid) begin
                push = '{valid: 1'b1, sym: pend_sym, status: pend_status, last: 1'b0};
              end
              pend_valid_next  = 1'b1;
              pend_sym_next    = '0;
              pend_status_next = htd_pkg::STAT_BAD_CODE;
              walk_pos_next    = '0;
              byte_sh_next     = {byte_sh[htd_pkg::BYTE_W-2:0], 1'b0};
              bits_left_next   = bits_left - 1'b1;
            end
          end else begin
            walk_pos_next  = child;
            byte_sh_next   = {byte_sh[htd_pkg::BYTE_W-2:0], 1'b0};
            bits_left_next = bits_left - 1'b1;
          end
        end else begin
          state_next = htd_pkg::S_FLUSH;
        end
      end

      htd_pkg::S_FLUSH: begin
        // the held result is the final one of this request
        if (pend_valid) begin
          if (out_room) begin
            push = '{valid: 1'b1, sym: pend_sym, status: pend_status, last: 1'b1};
            pend_valid_next = 1'b0;
            state_next      = htd_pkg::S_IDLE;
          end
        end else begin
          state_next = htd_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = htd_pkg::S_IDLE;
      end
    endcase

    // keep the read data tracking the node that the next cycle looks at
    rd_addr = (state_next == htd_pkg::S_LD_WALK) ? cur_next : walk_pos_next;
  end

endmodule

`default_nettype wire

/* hdl/huffman_tree_decoder_unit.sv */
// Huffman tree decoder with a loadable node table.
// Requests enter on the s_ group: s_tuser selects load code, decode byte or
// clear table; s_tdata carries the code entry and data byte fields.
// Results leave on the m_ group: m_tdata is the symbol, m_tuser the status
// (symbol, load ok, bad code, table full), m_tlast marks the final result of
// a request. A request that gives no result (clear, empty decode) sends none.
// One request is worked on at a time; s_tready is high only while idle.
// Load: walks the existing part of the path through the node memory read port,
// builds each missing node, then writes the symbol. Decode: walks the tree bit
// by bit, emits each decoded symbol in a step of its own, then flushes the
// held result; emits wait while the output has no room.
// A result is held back until it is known whether it is the last;
// the output register lets the next step run while a result waits.
// Reset (synchronous, rst high) empties the tree, walk returns to the root;
// the root lives in flip-flops, so no memory clearing pass is needed.
// A stalled receiver holds m_tvalid and the result; the sequencer waits once it must pass on another result.
// Uses htd_pkg, htd_ctrl.
`default_nettype none

module huffman_tree_decoder_unit (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  // symbol_in[7:0], code_bits[39:8], code_length[45:40], data_byte[53:46],
  // valid_bits[57:54], zero fill [63:58]
  input  wire [63:0] s_tdata,
  // func[1:0]
  input  wire [1:0]  s_tuser,
  output logic       m_tvalid,
  input  wire        m_tready,
  // symbol_out[7:0]
  output logic [7:0] m_tdata,
  // status[1:0]
  output logic [1:0] m_tuser,
  output logic       m_tlast
);

  htd_pkg::result_t            push;
  logic                        out_room;
  logic [htd_pkg::SYM_W-1:0]   out_sym;
  htd_pkg::status_t            out_status;
  logic                        out_last;

  assign out_room = !m_tvalid || m_tready;

  htd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (s_tvalid),
    .req_ready   (s_tready),
    .func        (htd_pkg::func_t'(s_tuser)),
    .symbol_in   (s_tdata[7:0]),
    .code_bits   (s_tdata[39:8]),
    .code_length (s_tdata[45:40]),
    .data_byte   (s_tdata[53:46]),
    .valid_bits  (s_tdata[57:54]),
    .out_room    (out_room),
    .push        (push)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_sym    <= push.sym;
      out_status <= push.status;
      out_last   <= push.last;
    end
  end

  assign m_tdata = out_sym;
  assign m_tuser = out_status;
  assign m_tlast = out_last;

endmodule

`default_nettype wire

/* hdl/htd_checker.sv */
// Port-level checks of the Huffman tree decoder, bound to the top level.
// Uses htd_pkg for the status codes.
`default_nettype none

module htd_checker (
  input wire       clk,
  input wire       rst,
  input wire       s_tvalid,
  input wire       s_tready,
  input wire       m_tvalid,
  input wire       m_tready,
  input wire [7:0] m_tdata,
  input wire [1:0] m_tuser,
  input wire       m_tlast
);

  // one request at a time: busy right after an accepted request
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("accepted a request back to back");

  // a load answers with a single result, so a load result always carries last
  a_load_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == htd_pkg::STAT_LOAD_OK || m_tuser == htd_pkg::STAT_FULL))
      |-> m_tlast)
    else $error("load result without last");

  // only a decoded symbol carries a nonzero symbol byte
  a_sym_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != htd_pkg::STAT_SYMBOL) |-> (m_tdata == 8'd0))
    else $error("status result with nonzero symbol");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind huffman_tree_decoder_unit htd_checker u_htd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

/* tb/tb_huffman_tree_decoder_unit.sv */
// Self-checking testbench for huffman_tree_decoder_unit: loads prefix code
// tables, decodes packed bit streams and checks every result against a node-table predictor.
// Depends on htd_pkg and the huffman_tree_decoder_unit RTL.

module tb_huffman_tree_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam int         RANDOM_ITEMS = 380;
  localparam int         CYCLE_LIMIT  = 1_000_000;
  localparam int         TAIL_CYCLES  = 40;

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  sym;
    logic [31:0] code_bits;
    logic [5:0]  code_len;
    logic [7:0]  data_byte;
    logic [3:0]  vb;
    bit          hold;
  } code_req_t;

  typedef struct {
    logic [7:0]       sym;
    htd_pkg::status_t status;
    logic             last;
  } tree_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  huffman_tree_decoder_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  code_req_t    code_req_q[$];
  tree_result_t tree_results_q[$];
  bit           hold_next = 1'b0;
  int           random_items = 0;
  int           total_reqs = 1;
  int           reqs_sent = 0;
  int           fail_count = 0;
  int           cycle_count = 0;
  int           loads_seen = 0, decodes_seen = 0, clears_seen = 0;
  int           results_seen = 0, symbols_seen = 0, bad_seen = 0, full_seen = 0;

  // Predictor state: node links, node symbols, allocation count, walk node.
  logic [htd_pkg::NODE_W-1:0] tree_left  [htd_pkg::NODES];
  logic [htd_pkg::NODE_W-1:0] tree_right [htd_pkg::NODES];
  logic [7:0]                 tree_sym   [htd_pkg::NODES];
  int                         tree_count;
  int                         walk_node;

  initial forever #5 clk = ~clk;

  function automatic void tree_clear();
    for (int i = 0; i < htd_pkg::NODES; i++) begin
      tree_left[i]  = '0;
      tree_right[i] = '0;
      tree_sym[i]   = '0;
    end
    tree_count = 1;
    walk_node  = 0;
  endfunction

  function automatic htd_pkg::status_t tree_insert(logic [7:0] s, logic [31:0] cb,
                                                   logic [5:0] ln);
    int len, depth, node, nxt;
    logic b;
    len = int'(ln);
    if (len > htd_pkg::MAX_CODE_LEN) len = htd_pkg::MAX_CODE_LEN;
    if (len == 0) return htd_pkg::STAT_LOAD_OK;
    // measure how much of the path already exists
    node = 0;
    depth = 0;
    while (depth < len) begin
      nxt = int'(cb[len-1-depth] ? tree_right[node] : tree_left[node]);
      if (nxt == 0) break;
      node = nxt;
      depth++;
    end
    if (tree_count + (len - depth) > htd_pkg::NODES) return htd_pkg::STAT_FULL;
    node = 0;
    for (int i = 0; i < len; i++) begin
      b = cb[len-1-i];
      nxt = int'(b ? tree_right[node] : tree_left[node]);
      if (nxt == 0) begin
        nxt = tree_count;
        tree_left[nxt]  = '0;
        tree_right[nxt] = '0;
        tree_sym[nxt]   = '0;
        tree_count++;
        if (b) tree_right[node] = htd_pkg::NODE_W'(nxt);
        else tree_left[node] = htd_pkg::NODE_W'(nxt);
      end
      node = nxt;
    end
    tree_sym[node] = s;
    return htd_pkg::STAT_LOAD_OK;
  endfunction

  function automatic void tree_apply(code_req_t r);
    logic [7:0]       osym [8];
    htd_pkg::status_t ost  [8];
    tree_result_t     res;
    int               n, nb, nxt;
    logic             b;
    n = 0;
    if (r.func == htd_pkg::FUNC_LOAD) begin
      loads_seen++;
      osym[0] = '0;
      ost[0]  = tree_insert(r.sym, r.code_bits, r.code_len);
      n = 1;
    end else if (r.func == htd_pkg::FUNC_DECODE) begin
      decodes_seen++;
      nb = (r.vb > 4'd8) ? 8 : int'(r.vb);
      for (int i = 0; i < nb; i++) begin
        b = r.data_byte[7-i];
        nxt = int'(b ? tree_right[walk_node] : tree_left[walk_node]);
        if (nxt == 0) begin
          osym[n] = '0;
          ost[n]  = htd_pkg::STAT_BAD_CODE;
          n++;
          walk_node = 0;
        end else begin
          walk_node = nxt;
          if (tree_left[nxt] == '0 && tree_right[nxt] == '0) begin
            osym[n] = tree_sym[nxt];
            ost[n]  = htd_pkg::STAT_SYMBOL;
            n++;
            walk_node = 0;
          end
        end
      end
    end else if (r.func == htd_pkg::FUNC_CLEAR) begin
      clears_seen++;
      tree_clear();
    end
    for (int i = 0; i < n; i++) begin
      res.sym    = osym[i];
      res.status = ost[i];
      res.last   = (i == n - 1);
      tree_results_q.push_back(res);
    end
  endfunction

  task automatic push_req(logic [1:0] f, logic [7:0] s, logic [31:0] cb, logic [5:0] ln,
                          logic [7:0] db, logic [3:0] vb);
    code_req_t r;
    r.func = f;
    r.sym = s;
    r.code_bits = cb;
    r.code_len = ln;
    r.data_byte = db;
    r.vb = vb;
    r.hold = hold_next;
    hold_next = 1'b0;
    code_req_q.push_back(r);
    // ignored requests do not count toward the random budget
    if (f != FUNC_UNUSED && !(f == htd_pkg::FUNC_DECODE && vb == 4'd0)) random_items++;
  endtask

  task automatic load_req(logic [7:0] s, logic [31:0] cb, logic [5:0] ln);
    push_req(htd_pkg::FUNC_LOAD, s, cb, ln, 8'($urandom), 4'($urandom));
  endtask

  task automatic decode_req(logic [7:0] db, logic [3:0] vb);
    push_req(htd_pkg::FUNC_DECODE, 8'($urandom), $urandom, 6'($urandom), db, vb);
  endtask

  task automatic plain_req(logic [1:0] f);
    push_req(f, 8'($urandom), $urandom, 6'($urandom), 8'($urandom), 4'($urandom));
  endtask

  // Build a random prefix code, load it, then decode a packed stream of its codes.
  task automatic coded_stream_session(bit deep, bit drop_leaf);
    logic [31:0] codes[$];
    int          lens[$];
    int          order[$];
    bit          bit_stream[$];
    logic [31:0] c, cb;
    logic [7:0]  db;
    logic [5:0]  ln;
    logic [3:0]  vbits;
    int          n, l, pick, idx, drop, max_len, n_syms, take;
    hold_next = 1'b1;
    if ($urandom_range(3) != 0) plain_req(htd_pkg::FUNC_CLEAR);
    n = deep ? $urandom_range(20, 33) : $urandom_range(2, 24);
    max_len = deep ? 32 : 12;
    codes.push_back('0);
    lens.push_back(0);
    while (codes.size() < n) begin
      pick = deep ? codes.size() - 1 : $urandom_range(codes.size() - 1);
      if (lens[pick] < max_len) begin
        c = codes[pick];
        l = lens[pick];
        codes[pick] = c << 1;
        lens[pick] = l + 1;
        codes.push_back((c << 1) | 32'd1);
        lens.push_back(l + 1);
      end
    end
    drop = drop_leaf ? $urandom_range(n - 1) : -1;
    for (int i = 0; i < n; i++) order.push_back(i);
    while (order.size() > 0) begin
      pick = $urandom_range(order.size() - 1);
      idx = order[pick];
      order.delete(pick);
      if (idx != drop) begin
        // junk above the code length must be ignored
        cb = codes[idx] | (32'($urandom) << lens[idx]);
        ln = 6'(lens[idx]);
        if (lens[idx] == 32 && $urandom_range(1) == 0) ln = 6'($urandom_range(33, 63));
        load_req(8'($urandom), cb, ln);
      end
    end
    if ($urandom_range(3) == 0) begin
      idx = $urandom_range(n - 1);
      load_req(8'($urandom), codes[idx], 6'(lens[idx]));
    end
    n_syms = deep ? $urandom_range(3, 10) : $urandom_range(4, 40);
    repeat (n_syms) begin
      idx = $urandom_range(n - 1);
      for (int j = lens[idx] - 1; j >= 0; j--) bit_stream.push_back(codes[idx][j]);
    end
    while (bit_stream.size() > 0) begin
      take = bit_stream.size();
      if (take > 8) take = 8;
      if (take == 8 && $urandom_range(9) == 0) take = $urandom_range(1, 7);
      db = 8'($urandom);
      for (int j = 0; j < take; j++) db[7-j] = bit_stream.pop_front();
      vbits = 4'(take);
      if (take == 8 && $urandom_range(9) == 0) vbits = 4'($urandom_range(9, 15));
      decode_req(db, vbits);
    end
  endtask

  task automatic noise_session();
    hold_next = 1'b1;
    repeat ($urandom_range(3, 10)) begin
      case ($urandom_range(9))
        0, 1, 2, 3: decode_req(8'($urandom), 4'($urandom_range(0, 15)));
        4, 5, 6: load_req(8'($urandom), $urandom,
                          6'($urandom_range(1) ? $urandom_range(0, 8) : $urandom_range(0, 63)));
        7: plain_req(htd_pkg::FUNC_CLEAR);
        8: plain_req(FUNC_UNUSED);
        default: decode_req(8'($urandom), 4'd8);
      endcase
    end
  endtask

  // Long random codes until the node table runs out.
  task automatic fill_session();
    hold_next = 1'b1;
    plain_req(htd_pkg::FUNC_CLEAR);
    repeat ($urandom_range(17, 22)) load_req(8'($urandom), $urandom, 6'($urandom_range(26, 40)));
    repeat ($urandom_range(1, 3)) load_req(8'($urandom), $urandom, 6'($urandom_range(1, 3)));
    repeat ($urandom_range(2, 5)) decode_req(8'($urandom), 4'd8);
  endtask

  function automatic int idle_phase();
    int p;
    p = reqs_sent * 3 / total_reqs;
    return (p > 2) ? 2 : p;
  endfunction

  always @(posedge clk) begin : request_driver
    code_req_t cur_req;
    int        idle_pct;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        tree_apply(cur_req);
        reqs_sent++;
      end
      if (!s_tvalid || s_tready) begin
        case (idle_phase())
          0: idle_pct = 13;
          1: idle_pct = 79;
          default: idle_pct = 0;
        endcase
        if (code_req_q.size() > 0 && !(code_req_q[0].hold && tree_results_q.size() > 0) &&
            $urandom_range(99) >= idle_pct) begin
          cur_req = code_req_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= cur_req.func;
          s_tdata  <= {6'd0, cur_req.vb, cur_req.data_byte, cur_req.code_len,
                       cur_req.code_bits, cur_req.sym};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endfunction

  always @(posedge clk) begin : result_monitor
    tree_result_t exp_r;
    int           stall_pct;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (m_tuser == htd_pkg::STAT_SYMBOL) symbols_seen++;
        if (m_tuser == htd_pkg::STAT_BAD_CODE) bad_seen++;
        if (m_tuser == htd_pkg::STAT_FULL) full_seen++;
        if (tree_results_q.size() == 0) begin
          note_failure($sformatf("unexpected result: sym %02h status %0d last %0b",
                                 m_tdata, m_tuser, m_tlast));
        end else begin
          exp_r = tree_results_q.pop_front();
          if (m_tdata !== exp_r.sym || m_tuser !== exp_r.status || m_tlast !== exp_r.last)
            note_failure({$sformatf("mismatch at result %0d: got sym %02h status %0d last %0b",
                                    results_seen, m_tdata, m_tuser, m_tlast),
                          $sformatf(", expected sym %02h status %0d last %0b",
                                    exp_r.sym, exp_r.status, exp_r.last)});
        end
      end
      case (idle_phase())
        0: stall_pct = 79;
        1: stall_pct = 13;
        default: stall_pct = 0;
      endcase
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               tree_results_q.size());
      $display("huffman_tree_decoder_unit regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int session, kind;
    tree_clear();

    // empty tree: every bit is a bad code
    decode_req(8'hA5, 4'd8);
    load_req(8'h3C, $urandom, 6'd0);
    load_req(8'hFF, 32'h0, 6'd1);
    load_req(8'h00, 32'h1, 6'd1);
    decode_req(8'hFF, 4'd8);
    decode_req(8'h00, 4'd15);
    decode_req(8'h5F, 4'd0);
    decode_req(8'h80, 4'd1);
    plain_req(FUNC_UNUSED);
    decode_req(8'h40, 4'd2);
    plain_req(htd_pkg::FUNC_CLEAR);
    // overlong length saturates to a 32-bit path of ones
    load_req(8'h5A, 32'hFFFF_FFFF, 6'd63);
    load_req(8'hC3, 32'h8000_0000, 6'd32);
    repeat (4) decode_req(8'hFF, 4'd8);
    // existing path: overwrite its symbol
    load_req(8'h11, 32'hFFFF_FFFF, 6'd32);
    decode_req(8'h80, 4'd8);
    repeat (3) decode_req(8'h00, 4'd8);
    // walk stops mid-code, then a missing link
    repeat (2) decode_req(8'hFF, 4'd8);
    decode_req(8'h00, 4'd8);

    session = 0;
    while (random_items < RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      if (session == 1 || kind >= 90) fill_session();
      else if (kind < 55) coded_stream_session(1'b0, 1'b0);
      else if (kind < 65) coded_stream_session(1'b0, 1'b1);
      else if (kind < 75) coded_stream_session(1'b1, 1'b0);
      else noise_session();
      session++;
    end
    total_reqs = code_req_q.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (code_req_q.size() != 0 || s_tvalid) @(posedge clk);
    while (tree_results_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d requests in %0d sessions: %0d loads, %0d decodes, %0d clears",
             reqs_sent, session, loads_seen, decodes_seen, clears_seen);
    $display("checked %0d results: %0d symbols, %0d bad codes, %0d table full; %0d failures",
             results_seen, symbols_seen, bad_seen, full_seen, fail_count);
    if (fail_count == 0) begin
      $display("huffman_tree_decoder_unit regression: pass");
    end else begin
      $display("huffman_tree_decoder_unit regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/htd_pkg.sv
hdl/htd_node_mem.sv
hdl/htd_step.sv
hdl/htd_ctrl.sv
hdl/huffman_tree_decoder_unit.sv
hdl/htd_checker.sv
tb/tb_huffman_tree_decoder_unit.sv
